// File: src/aop_pkg.sv
`default_nettype none

package aop_pkg;

    localparam int MAX_SIZE_DEF = 1024;

    localparam int SIZE_W = 11;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd1024;
    localparam logic [CNT_W-1:0]  COUNT_LIMIT = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// File: src/aop_bin_mem.sv
`default_nettype none

module aop_bin_mem #(
    parameter int DEPTH = 2 * aop_pkg::MAX_SIZE_DEF - 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [aop_pkg::CNT_W-1:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [aop_pkg::CNT_W-1:0] o_rdata
);
    import aop_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/aop_step_unit.sv
`default_nettype none

// shared add and compare: bin index, count increment, cursor and sweep steps
module aop_step_unit #(
    parameter int SW = 12
) (
    input  wire logic [SW-1:0] i_a,
    input  wire logic [SW-1:0] i_b,
    input  wire logic [SW-1:0] i_limit,
    output logic      [SW-1:0] o_sum,
    output logic               o_lt
);

    assign o_sum = i_a + i_b;
    assign o_lt  = (o_sum < i_limit);

endmodule

`default_nettype wire

// File: src/antidiagonal_occupancy_profiler_unit.sv
`default_nettype none

// An add passes ST_ADD_RD and ST_ADD_WR to ST_RESULT; a rejected add goes straight to ST_RESULT.
// A fetch alternates ST_SCAN_RD and ST_SCAN_CHK per bin examined from the cursor, then goes
// to ST_RESULT, also when the scan runs off the end. One item at a time: the next is taken once
// the result is loaded into the output register, which a stalled output can hold off.
// An exhausted fetch, and reset (i_rst_n low, synchronous), start a sweep clearing all
// 2*MAX_SIZE-1 bins of the bin memory, during which no item is taken; the size may be written.
module antidiagonal_occupancy_profiler_unit #(
    parameter int MAX_SIZE = aop_pkg::MAX_SIZE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration: matrix order
    input  wire logic                              i_cfg_we,
    input  wire logic        [aop_pkg::SIZE_W-1:0] i_cfg_data,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_in_opcode,
    input  wire logic        [aop_pkg::IDX_W-1:0]  i_in_row_index,
    input  wire logic        [aop_pkg::IDX_W-1:0]  i_in_col_index,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed      [aop_pkg::SIZE_W-1:0] o_out_diag_offset,
    output logic             [aop_pkg::CNT_W-1:0]  o_out_diag_count,
    output logic                                   o_out_found,
    output logic             [aop_pkg::CNT_W-1:0]  o_out_distinct_diagonals,
    output logic                                   o_out_bad_index
);
    import aop_pkg::*;

    // bins 0 .. 2*MAX_SIZE-2; cursor may sit one past the last bin
    localparam int DEPTH = 2 * MAX_SIZE - 1;
    localparam int BW    = $clog2(DEPTH);
    localparam int CW    = $clog2(2 * MAX_SIZE);
    localparam int SW    = (CW > SIZE_W + 1) ? CW : SIZE_W + 1;

    t_state r_state, n_state;

    logic [SIZE_W-1:0]        r_size;
    logic [SIZE_W-1:0]        size_act;
    logic [SIZE_W:0]          bins_used;

    logic [IDX_W-1:0]         r_row, n_row;
    logic [IDX_W-1:0]         r_col, n_col;
    logic [BW-1:0]            r_addr, n_addr;
    logic [CW-1:0]            r_cur, n_cur;
    logic [CNT_W-1:0]         r_total, n_total;
    logic                     r_clr_pend, n_clr_pend;

    // result being built
    logic signed [SIZE_W-1:0] r_offset, n_offset;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_found, n_found;
    logic                     r_bad, n_bad;

    // output register
    logic                     r_out_valid;
    logic signed [SIZE_W-1:0] r_out_offset;
    logic [CNT_W-1:0]         r_out_count;
    logic                     r_out_found;
    logic [CNT_W-1:0]         r_out_distinct;
    logic                     r_out_bad;

    logic                     in_accept;
    logic                     add_bad;
    logic                     out_load;

    logic [SW-1:0]            step_a, step_b, step_limit, step_sum;
    logic                     step_lt;

    logic                     mem_we;
    logic [BW-1:0]            mem_waddr, mem_raddr;
    logic [CNT_W-1:0]         mem_wdata, mem_rdata;

    // size 0 acts as 1, sizes past MAX_SIZE are capped
    always_comb begin
        if (r_size == '0) begin
            size_act = SIZE_W'(1);
        end else if (32'(r_size) > MAX_SIZE) begin
            size_act = SIZE_W'(MAX_SIZE);
        end else begin
            size_act = r_size;
        end
    end

    assign bins_used = {size_act, 1'b0} - (SIZE_W + 1)'(1);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign add_bad    = ({1'b0, i_in_row_index} >= size_act) ||
                        ({1'b0, i_in_col_index} >= size_act);
    // result leaves when the output register is free or being emptied
    assign out_load   = (r_state == ST_RESULT) && (!r_out_valid || !i_out_stall);

    aop_step_unit #(
        .SW      (SW)
    ) u_step (
        .i_a     (step_a),
        .i_b     (step_b),
        .i_limit (step_limit),
        .o_sum   (step_sum),
        .o_lt    (step_lt)
    );

    aop_bin_mem #(
        .DEPTH   (DEPTH),
        .AW      (BW)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (!step_lt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_opcode == OP_FETCH) begin
                        n_state = ST_SCAN_RD;
                    end else if (add_bad) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD:  n_state = ST_ADD_WR;
            ST_ADD_WR:  n_state = ST_RESULT;
            ST_SCAN_RD: n_state = step_lt ? ST_SCAN_CHK : ST_RESULT;
            ST_SCAN_CHK: begin
                n_state = (mem_rdata != '0) ? ST_RESULT : ST_SCAN_RD;
            end
            ST_RESULT: begin
                if (out_load) begin
                    n_state = r_clr_pend ? ST_CLEAR : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath control
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_cur      = r_cur;
        n_total    = r_total;
        n_clr_pend = r_clr_pend;
        n_offset   = r_offset;
        n_count    = r_count;
        n_found    = r_found;
        n_bad      = r_bad;
        step_a     = '0;
        step_b     = '0;
        step_limit = '0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = '0;
        mem_raddr  = r_addr;
        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                step_a     = SW'(r_addr);
                step_b     = SW'(1);
                step_limit = SW'(DEPTH);
                n_addr     = BW'(step_sum);
                if (!step_lt) begin
                    n_clr_pend = 1'b0;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_row    = i_in_row_index;
                    n_col    = i_in_col_index;
                    n_offset = '0;
                    n_count  = '0;
                    n_found  = 1'b0;
                    n_bad    = (i_in_opcode == OP_ADD) && add_bad;
                end
            end
            ST_ADD_RD: begin
                step_a    = SW'(r_row);
                step_b    = SW'(r_col);
                mem_raddr = BW'(step_sum);
                n_addr    = BW'(step_sum);
            end
            ST_ADD_WR: begin
                // increment unless already at the limit
                step_a     = SW'(mem_rdata);
                step_b     = SW'(1);
                step_limit = SW'(COUNT_LIMIT) + SW'(1);
                mem_we     = step_lt;
                mem_wdata  = CNT_W'(step_sum);
                if (mem_rdata == '0) begin
                    n_total = r_total + CNT_W'(1);
                end
            end
            ST_SCAN_RD: begin
                step_a     = SW'(r_cur);
                step_limit = SW'(bins_used);
                mem_raddr  = BW'(r_cur);
                if (!step_lt) begin
                    // nothing left: empty the store
                    n_total    = '0;
                    n_cur      = '0;
                    n_clr_pend = 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                step_a = SW'(r_cur);
                step_b = SW'(1);
                n_cur  = CW'(step_sum);
                if (mem_rdata != '0) begin
                    n_found   = 1'b1;
                    n_count   = mem_rdata;
                    n_offset  = $signed(SIZE_W'(r_cur) - size_act + SIZE_W'(1));
                    mem_we    = 1'b1;
                    mem_waddr = BW'(r_cur);
                end
            end
            ST_RESULT: begin
                if (out_load && r_clr_pend) begin
                    n_addr = '0;
                end
            end
            default: begin
                n_clr_pend = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_size      <= SIZE_RESET;
            r_addr      <= '0;
            r_cur       <= '0;
            r_total     <= '0;
            r_clr_pend  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_cur      <= n_cur;
            r_total    <= n_total;
            r_clr_pend <= n_clr_pend;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_offset <= n_offset;
        r_count  <= n_count;
        r_found  <= n_found;
        r_bad    <= n_bad;
        if (out_load) begin
            r_out_offset   <= r_offset;
            r_out_count    <= r_count;
            r_out_found    <= r_found;
            r_out_distinct <= r_total;
            r_out_bad      <= r_bad;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_out_diag_offset        = r_out_offset;
    assign o_out_diag_count         = r_out_count;
    assign o_out_found              = r_out_found;
    assign o_out_distinct_diagonals = r_out_distinct;
    assign o_out_bad_index          = r_out_bad;

    // a found diagonal always carries a count within the saturation limit
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_found) |->
            (o_out_diag_count != '0) && (o_out_diag_count <= COUNT_LIMIT))
        else $error("found item with bad count");

    // a rejected add never reports a diagonal
    a_bad_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_bad_index) |-> !o_out_found)
        else $error("rejected add reported a diagonal");

    // bin writes never exceed the saturation limit
    a_wdata_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wdata <= COUNT_LIMIT))
        else $error("bin count above limit");

    // cursor stays within the bin range or one past the last bin
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) <= DEPTH)
        else $error("scan cursor out of range");

    // an exhausted fetch leaves an empty store and a clearing sweep
    a_exhaust_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_RD && !step_lt) |=>
            (r_total == '0) && r_clr_pend && (r_state == ST_RESULT))
        else $error("exhausted fetch did not empty the store");

endmodule

`default_nettype wire
